// File: sv/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define DRPP_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// condition implies consequence in the next cycle
`define DRPP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// File: sv/drpp_pkg.sv
package drpp_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam int AGE_Q_BITS    = 16;
  localparam int PRIO_W        = 17;
  localparam int IDX_W         = 6;
  localparam int ARR_W         = 32;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 21;
  localparam int FIFO_DEPTH    = 2;

  localparam logic [2:0] PRIO_DEMAND_HI  = 3'd7;
  localparam logic [2:0] PRIO_DEMAND_MID = 3'd6;
  localparam logic [2:0] PRIO_DEMAND_LO  = 3'd5;
  localparam logic [2:0] PRIO_PF_ONE     = 3'd4;
  localparam logic [2:0] PRIO_PF_TWO     = 3'd3;
  localparam logic [2:0] PRIO_PF_THREE   = 3'd2;
  localparam logic [2:0] PRIO_PF_FOUR    = 3'd1;
  localparam logic [2:0] PRIO_PF_NONE    = 3'd0;
  localparam logic [PRIO_W-1:0] PRIO_DROP_CAP = PRIO_W'(4);
  localparam logic [AGE_Q_BITS-1:0] AGE_CAP   = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEM_ONE,
    CFG_DEM_TWO,
    CFG_PF_ONE,
    CFG_PF_TWO,
    CFG_PF_THREE,
    CFG_PF_FOUR,
    CFG_AGE_INTERVAL,
    CFG_DROP_ENABLE
  } cfg_idx_e;

  typedef enum logic {
    REQ_TICK,
    REQ_ENTRY
  } req_type_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_PICK
  } back_state_e;

  typedef struct packed {
    logic                    req_type;
    logic                    entry_ready;
    logic                    prefetch_req;
    logic                    strict_priority;
    logic signed [15:0]      prefetch_distance;
    logic [ARR_W-1:0]        arrival_cycle;
    logic [14:0]             core_occupancy;
    logic [IDX_W-1:0]        entry_index;
    logic                    first_entry;
    logic                    last_entry;
  } in_word_t;

  typedef struct packed {
    logic             drop_mark;
    logic             scan_done;
    logic [IDX_W-1:0] winner_index;
  } out_word_t;

  typedef struct packed {
    logic signed [15:0] demand_level_one;
    logic signed [15:0] demand_level_two;
    logic signed [15:0] prefetch_level_one;
    logic signed [15:0] prefetch_level_two;
    logic signed [15:0] prefetch_level_three;
    logic signed [15:0] prefetch_level_four;
    logic [20:0]        age_interval;
    logic               drop_enable;
  } cfg_t;

  typedef struct packed {
    logic             entry_ready;
    logic             prefetch_req;
    logic             strict_priority;
    logic [2:0]       base_prio;
    logic [ARR_W-1:0] arrival_cycle;
    logic [IDX_W-1:0] entry_index;
    logic             first_entry;
    logic             last_entry;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// File: sv/drpp_front.sv
module drpp_front #(
  parameter int TIME_BITS = drpp_pkg::TIME_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  drpp_pkg::in_word_t  in_word_i,
  input  drpp_pkg::cfg_t      cfg_i,
  input  drpp_pkg::q_status_t q_status_i,
  output logic                push_o,
  output drpp_pkg::item_t     item_o,
  output logic [TIME_BITS-1:0] age_o
);
  import drpp_pkg::*;

  localparam int EXT_W = (TIME_BITS > ARR_W) ? TIME_BITS : ARR_W;

  logic [TIME_BITS-1:0] cycle_q, cycle_d;
  logic                 accept;
  logic [EXT_W-1:0]     age_ext;
  logic signed [15:0]   occ_s;
  logic [2:0]           base;

  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !q_status_i.full;
  assign push_o     = accept && (in_word_i.req_type == REQ_ENTRY);

  always_comb begin
    cycle_d = cycle_q;
    if (accept && (in_word_i.req_type == REQ_TICK)) begin
      cycle_d = cycle_q + TIME_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cycle_q <= '1;
    end else begin
      cycle_q <= cycle_d;
    end
  end

  // age wraps modulo the counter width
  assign age_ext = EXT_W'(cycle_q) - EXT_W'(in_word_i.arrival_cycle);
  assign age_o   = age_ext[TIME_BITS-1:0];

  assign occ_s = $signed({1'b0, in_word_i.core_occupancy});

  always_comb begin
    if (in_word_i.prefetch_req) begin
      if (cfg_i.prefetch_level_one > in_word_i.prefetch_distance) begin
        base = PRIO_PF_ONE;
      end else if (cfg_i.prefetch_level_two > in_word_i.prefetch_distance) begin
        base = PRIO_PF_TWO;
      end else if (cfg_i.prefetch_level_three > in_word_i.prefetch_distance) begin
        base = PRIO_PF_THREE;
      end else if (cfg_i.prefetch_level_four > in_word_i.prefetch_distance) begin
        base = PRIO_PF_FOUR;
      end else begin
        base = PRIO_PF_NONE;
      end
    end else begin
      if (cfg_i.demand_level_one > occ_s) begin
        base = PRIO_DEMAND_HI;
      end else if (cfg_i.demand_level_two > occ_s) begin
        base = PRIO_DEMAND_MID;
      end else begin
        base = PRIO_DEMAND_LO;
      end
    end
  end

  always_comb begin
    item_o.entry_ready     = in_word_i.entry_ready;
    item_o.prefetch_req    = in_word_i.prefetch_req;
    item_o.strict_priority = in_word_i.strict_priority;
    item_o.base_prio       = base;
    item_o.arrival_cycle   = in_word_i.arrival_cycle;
    item_o.entry_index     = in_word_i.entry_index;
    item_o.first_entry     = in_word_i.first_entry;
    item_o.last_entry      = in_word_i.last_entry;
  end

endmodule

// File: sv/drpp_fifo.sv
module drpp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = drpp_pkg::FIFO_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [WIDTH-1:0]    wdata_i,
  input  logic                pop_i,
  output logic [WIDTH-1:0]    rdata_o,
  output drpp_pkg::q_status_t status_o
);
  import drpp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign status_o.full  = (count_q == CNT_FULL);
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign rdata_o        = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// File: sv/drpp_back.sv
module drpp_back #(
  parameter int TIME_BITS = drpp_pkg::TIME_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  drpp_pkg::cfg_t       cfg_i,
  input  drpp_pkg::q_status_t  q_status_i,
  input  drpp_pkg::item_t      item_i,
  input  logic [TIME_BITS-1:0] age_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output drpp_pkg::out_word_t  out_word_o
);
  import drpp_pkg::*;

  localparam int DIV_W = TIME_BITS + 22;
  localparam logic [4:0] CNT_TOP = 5'(AGE_Q_BITS);

  back_state_e           state_q, state_d;
  item_t                 item_q, item_d;
  logic [DIV_W-1:0]      rem_q, rem_d;
  logic [4:0]            cnt_q, cnt_d;
  logic [AGE_Q_BITS-1:0] quo_q, quo_d;
  logic                  sat_q, sat_d;

  logic [IDX_W-1:0]  best_index_q, best_index_d;
  logic              best_ready_q, best_ready_d;
  logic              best_marked_q, best_marked_d;
  logic              best_strict_q, best_strict_d;
  logic [PRIO_W-1:0] best_prio_q, best_prio_d;
  logic [ARR_W-1:0]  best_arrival_q, best_arrival_d;

  logic      out_valid_q, out_valid_d;
  out_word_t out_word_q, out_word_d;

  logic [DIV_W-1:0]      divisor, shifted;
  logic                  fits;
  logic [AGE_Q_BITS-1:0] steps;
  logic [PRIO_W-1:0]     prio_raw, prio;
  logic                  over, marked, take, slot_free;

  assign divisor = (cfg_i.age_interval == '0) ? DIV_W'(1) : DIV_W'(cfg_i.age_interval);
  assign shifted = divisor << cnt_q;
  assign fits    = (rem_q >= shifted);

  assign steps    = sat_q ? AGE_CAP : quo_q;
  assign prio_raw = item_q.prefetch_req ? PRIO_W'(item_q.base_prio) + PRIO_W'(steps)
                                        : PRIO_W'(item_q.base_prio);
  assign over     = item_q.prefetch_req && cfg_i.drop_enable && (prio_raw > PRIO_DROP_CAP);
  assign prio     = over ? PRIO_DROP_CAP : prio_raw;
  // a lone entry is never marked
  assign marked   = over && !(item_q.first_entry && item_q.last_entry);

  always_comb begin
    if (item_q.first_entry) begin
      take = 1'b1;
    end else if (marked != best_marked_q) begin
      take = !marked;
    end else if (item_q.entry_ready != best_ready_q) begin
      take = item_q.entry_ready;
    end else if (item_q.strict_priority != best_strict_q) begin
      take = item_q.strict_priority;
    end else if (prio != best_prio_q) begin
      take = (prio > best_prio_q);
    end else begin
      take = (item_q.arrival_cycle < best_arrival_q);
    end
  end

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d        = state_q;
    item_d         = item_q;
    rem_d          = rem_q;
    cnt_d          = cnt_q;
    quo_d          = quo_q;
    sat_d          = sat_q;
    best_index_d   = best_index_q;
    best_ready_d   = best_ready_q;
    best_marked_d  = best_marked_q;
    best_strict_d  = best_strict_q;
    best_prio_d    = best_prio_q;
    best_arrival_d = best_arrival_q;
    out_valid_d    = out_valid_q && out_stall_i;
    out_word_d     = out_word_q;
    pop_o          = 1'b0;

    unique case (state_q)
      BK_IDLE: begin
        if (!q_status_i.empty) begin
          pop_o   = 1'b1;
          item_d  = item_i;
          rem_d   = DIV_W'(age_i);
          cnt_d   = CNT_TOP;
          quo_d   = '0;
          sat_d   = 1'b0;
          state_d = item_i.prefetch_req ? BK_DIV : BK_PICK;
        end
      end
      BK_DIV: begin
        // one quotient bit per cycle, top step only detects saturation
        if (fits) begin
          rem_d = rem_q - shifted;
          if (cnt_q == CNT_TOP) begin
            sat_d = 1'b1;
          end else begin
            quo_d[cnt_q[3:0]] = 1'b1;
          end
        end
        if ((fits && (cnt_q == CNT_TOP)) || (cnt_q == '0)) begin
          state_d = BK_PICK;
        end else begin
          cnt_d = cnt_q - 5'(1);
        end
      end
      BK_PICK: begin
        if (slot_free) begin
          if (take) begin
            best_index_d   = item_q.entry_index;
            best_ready_d   = item_q.entry_ready;
            best_marked_d  = marked;
            best_strict_d  = item_q.strict_priority;
            best_prio_d    = prio;
            best_arrival_d = item_q.arrival_cycle;
          end
          out_valid_d             = 1'b1;
          out_word_d.drop_mark    = marked;
          out_word_d.scan_done    = item_q.last_entry;
          out_word_d.winner_index = !item_q.last_entry ? '0 :
                                    take ? item_q.entry_index : best_index_q;
          state_d                 = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= BK_IDLE;
      out_valid_q    <= 1'b0;
      best_index_q   <= '0;
      best_ready_q   <= 1'b0;
      best_marked_q  <= 1'b0;
      best_strict_q  <= 1'b0;
      best_prio_q    <= '0;
      best_arrival_q <= '0;
    end else begin
      state_q        <= state_d;
      out_valid_q    <= out_valid_d;
      best_index_q   <= best_index_d;
      best_ready_q   <= best_ready_d;
      best_marked_q  <= best_marked_d;
      best_strict_q  <= best_strict_d;
      best_prio_q    <= best_prio_d;
      best_arrival_q <= best_arrival_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    rem_q      <= rem_d;
    cnt_q      <= cnt_d;
    quo_q      <= quo_d;
    sat_q      <= sat_d;
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// File: sv/dram_request_priority_picker.sv
// the back takes entries from the two-word queue between front and back one at a time:
// it pops one in its idle state, runs a prefetch entry through the bit-serial age divider
// (one quotient bit per cycle) and judges it in its pick state, which registers the result
// word and waits while it is stalled; ticks are taken each cycle while the queue has room
// reset (async, active low): cycle counter all ones, running winner zero,
// thresholds -1, age interval 100, dropping enabled, queue and output empty
module dram_request_priority_picker #(
  parameter int TIME_BITS = drpp_pkg::TIME_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  drpp_pkg::in_word_t                 in_word_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output drpp_pkg::out_word_t                out_word_o,
  input  logic                               cfg_we_i,
  input  logic [drpp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [drpp_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);
  import drpp_pkg::*;

  localparam int Q_W = $bits(item_t) + TIME_BITS;

  cfg_t                 cfg_q, cfg_d;
  q_status_t            q_status;
  logic                 push, pop;
  item_t                front_item, back_item;
  logic [TIME_BITS-1:0] front_age, back_age;
  logic [Q_W-1:0]       q_rdata;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_DEM_ONE:      cfg_d.demand_level_one     = $signed(cfg_wdata_i[15:0]);
        CFG_DEM_TWO:      cfg_d.demand_level_two     = $signed(cfg_wdata_i[15:0]);
        CFG_PF_ONE:       cfg_d.prefetch_level_one   = $signed(cfg_wdata_i[15:0]);
        CFG_PF_TWO:       cfg_d.prefetch_level_two   = $signed(cfg_wdata_i[15:0]);
        CFG_PF_THREE:     cfg_d.prefetch_level_three = $signed(cfg_wdata_i[15:0]);
        CFG_PF_FOUR:      cfg_d.prefetch_level_four  = $signed(cfg_wdata_i[15:0]);
        CFG_AGE_INTERVAL: cfg_d.age_interval         = cfg_wdata_i[20:0];
        CFG_DROP_ENABLE:  cfg_d.drop_enable          = cfg_wdata_i[0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.demand_level_one     <= '1;
      cfg_q.demand_level_two     <= '1;
      cfg_q.prefetch_level_one   <= '1;
      cfg_q.prefetch_level_two   <= '1;
      cfg_q.prefetch_level_three <= '1;
      cfg_q.prefetch_level_four  <= '1;
      cfg_q.age_interval         <= 21'd100;
      cfg_q.drop_enable          <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  drpp_front #(
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .cfg_i      (cfg_q),
    .q_status_i (q_status),
    .push_o     (push),
    .item_o     (front_item),
    .age_o      (front_age)
  );

  drpp_fifo #(
    .WIDTH (Q_W),
    .DEPTH (FIFO_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .wdata_i  ({front_age, front_item}),
    .pop_i    (pop),
    .rdata_o  (q_rdata),
    .status_o (q_status)
  );

  assign back_item = q_rdata[$bits(item_t)-1:0];
  assign back_age  = q_rdata[Q_W-1:$bits(item_t)];

  drpp_back #(
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_status_i  (q_status),
    .item_i      (back_item),
    .age_i       (back_age),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

// File: sv/drpp_checker.sv
`include "assert_macros.svh"

module drpp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input drpp_pkg::out_word_t out_word_o
);
  import drpp_pkg::*;

  // a stalled result word stays offered
  `DRPP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // winner index is only reported with the last entry of a scan
  `DRPP_ASSERT_IMPLY(a_idx_idle, clk_i, rst_ni, out_valid_o && !out_word_o.scan_done, out_word_o.winner_index == '0)

  // the queue can only fill right after a word was taken in
  `DRPP_ASSERT_IMPLY(a_fill_after_take, clk_i, rst_ni, $rose(in_stall_o), $past(in_valid_i && !in_stall_o))

endmodule

bind dram_request_priority_picker drpp_checker u_checker (.*);
